// ----- rtl/svwe_pkg.sv -----
// Shared types, constants and the sine table generator for the sine voice.
// No dependencies; used by svwe_sine_rom and sine_voice_with_envelope_top.
package svwe_pkg;

    localparam int PHASE_W = 32;
    localparam int LEVEL_W = 17;   // Q1.16 envelope levels
    localparam int FACT_W  = 16;
    localparam int FS_W    = 15;
    localparam int SINE_W  = 15;   // magnitude of Q1.15 sine
    localparam int MUL_A_W = 30;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int OUT_W   = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'h1_0000;

    localparam logic [FACT_W-1:0] ATTACK_RST = 16'd62000;
    localparam logic [FACT_W-1:0] DECAY_RST  = 16'd65530;
    localparam logic [FS_W-1:0]   FS_RST     = 15'd16384;
    localparam logic [FACT_W-1:0] DROP_RST   = 16'd16;

    // Register indexes on the config port
    localparam logic [1:0] REG_ATTACK = 2'd0;
    localparam logic [1:0] REG_DECAY  = 2'd1;
    localparam logic [1:0] REG_FS     = 2'd2;
    localparam logic [1:0] REG_DROP   = 2'd3;

    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_NOTE_ON = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_ENV  = 8'b0000_0010,
        ST_SF   = 8'b0000_0100,
        ST_MAG  = 8'b0000_1000,
        ST_ATT  = 8'b0001_0000,
        ST_DEC  = 8'b0010_0000,
        ST_FIN  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } t_state;

    // Quarter-wave entry k of a 2^bits table: degree-9 odd polynomial in Q2.30,
    // Horner on x^2, scaled to Q1.15 with half-up rounding. Elaboration only.
    function automatic logic [SINE_W-1:0] rom_entry(input int unsigned k,
                                                    input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] v;
        x  = 64'(k) << (30 - bits);
        x2 = (x * x) >> 30;
        p  = 64'd172272;
        p  = 64'd5026999    - ((x2 * p) >> 30);
        p  = 64'd85569203   - ((x2 * p) >> 30);
        p  = 64'd693598343  - ((x2 * p) >> 30);
        p  = 64'd1686629713 - ((x2 * p) >> 30);
        v  = (x * p) >> 30;
        v  = (v * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

// ----- rtl/svwe_sine_rom.sv -----
// Quarter-wave sine table with a registered read port.
// Contents come from svwe_pkg::rom_entry, folded at elaboration.
module svwe_sine_rom #(
    parameter int TABLE_BITS = 8
) (
    input  logic                        i_clk,
    input  logic [TABLE_BITS:0]         i_addr,
    output logic [svwe_pkg::SINE_W-1:0] o_data
);

    localparam int SIZE = 1 << TABLE_BITS;

    logic [svwe_pkg::SINE_W-1:0] w_rom [0:SIZE];
    logic [svwe_pkg::SINE_W-1:0] r_data;

    for (genvar g = 0; g <= SIZE; g++) begin : g_rom
        assign w_rom[g] = svwe_pkg::rom_entry(g, TABLE_BITS);
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule

// ----- rtl/sine_voice_with_envelope_top.sv -----
// Monophonic sine voice with attack/decay envelope, top level.
// Depends on svwe_pkg and svwe_sine_rom.
//
// A note-on beat (tuser = 1) loads the phase step, clears the phase, resets
// both envelope levels to one and starts the voice; it gives no output beat.
// A tick beat (tuser = 0) gives one output beat. While the voice sounds a
// tick steps through ENV, SF, MAG, ATT, DEC and FIN, then OUT moves its
// result to the output register and the sequencer returns to IDLE. These
// steps are set by the single 30x17 multiplier that is used five times in
// turn (envelope, sine * full_scale, magnitude, attack update, decay update).
// A tick while silent goes from IDLE straight to OUT, which moves its zero
// sample to the output register. The input side
// is ready only between items; a finished result waits in the output
// register, so the next item can be taken before it is drained. A second
// result stalls the sequencer until that register frees up. Config writes are
// accepted any time but should only be made while the voice is idle.
module sine_voice_with_envelope_top #(
    parameter int SINE_TABLE_BITS = 8,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] phase_step
    input  logic        s_axis_tuser,   // [0] action (1 = note on)
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample (signed)
    output logic        m_axis_tuser    // [0] voice_active
);

    localparam int PHASE_W = svwe_pkg::PHASE_W;
    localparam int LEVEL_W = svwe_pkg::LEVEL_W;
    localparam int PROD_W  = svwe_pkg::PROD_W;
    localparam int MUL_A_W = svwe_pkg::MUL_A_W;
    localparam int MUL_B_W = svwe_pkg::MUL_B_W;
    localparam int OUT_W   = svwe_pkg::OUT_W;
    localparam int MAG_W   = PROD_W + 1 - 31;
    localparam int MW      = (SAMPLE_BITS > MAG_W ? SAMPLE_BITS : MAG_W) + 1;
    localparam logic [MW-1:0] MAX_POS = (MW'(1) << (SAMPLE_BITS - 1)) - MW'(1);
    localparam logic [MW-1:0] MAX_NEG = MW'(1) << (SAMPLE_BITS - 1);

    // config registers
    logic [svwe_pkg::FACT_W-1:0] r_attack_f;
    logic [svwe_pkg::FACT_W-1:0] r_decay_f;
    logic [svwe_pkg::FS_W-1:0]   r_fs;
    logic [svwe_pkg::FACT_W-1:0] r_drop;

    // voice state
    svwe_pkg::t_state r_state, n_state;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [PHASE_W-1:0] r_step, n_step;
    logic [LEVEL_W-1:0] r_att, n_att;
    logic [LEVEL_W-1:0] r_dec, n_dec;
    logic               r_active, n_active;

    // datapath
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [LEVEL_W-1:0] r_env, n_env;
    logic [OUT_W-1:0]   r_res_sample, n_res_sample;
    logic               r_res_act, n_res_act;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [OUT_W-1:0]   r_out_sample, n_out_sample;
    logic               r_out_act, n_out_act;

    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [PROD_W-1:0]  w_prod;
    logic [PROD_W:0]    w_round;
    logic [MW-1:0]      w_mag;
    logic [MW-1:0]      w_sat;
    logic [MW-1:0]      w_res;
    logic [OUT_W-1:0]   w_sample;
    logic [LEVEL_W-1:0] w_prod_lvl;
    logic               w_neg;
    logic               w_in_beat;
    logic               w_out_free;

    logic [SINE_TABLE_BITS-1:0] w_k;
    logic [SINE_TABLE_BITS:0]   w_rom_addr;
    logic [svwe_pkg::SINE_W-1:0] w_sine;

    // ---------------- sine table ----------------
    assign w_k = r_phase[PHASE_W-3 -: SINE_TABLE_BITS];
    // odd quadrants run the table backwards
    assign w_rom_addr = r_phase[PHASE_W-2]
                      ? ((SINE_TABLE_BITS+1)'(1) << SINE_TABLE_BITS) - {1'b0, w_k}
                      : {1'b0, w_k};
    assign w_neg = r_phase[PHASE_W-1];

    svwe_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_sine)
    );

    // ---------------- shared multiplier ----------------
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            svwe_pkg::ST_ENV: begin
                w_mul_a = MUL_A_W'(svwe_pkg::LEVEL_ONE - r_att);
                w_mul_b = MUL_B_W'(r_dec);
            end
            svwe_pkg::ST_SF: begin
                w_mul_a = MUL_A_W'(w_sine);
                w_mul_b = MUL_B_W'(r_fs);
            end
            svwe_pkg::ST_MAG: begin
                w_mul_a = r_prod[MUL_A_W-1:0];
                w_mul_b = MUL_B_W'(r_env);
            end
            svwe_pkg::ST_ATT: begin
                w_mul_a = MUL_A_W'(r_att);
                w_mul_b = MUL_B_W'(r_attack_f);
            end
            svwe_pkg::ST_DEC: begin
                w_mul_a = MUL_A_W'(r_dec);
                w_mul_b = MUL_B_W'(r_decay_f);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod     = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    assign w_prod_lvl = r_prod[16 +: LEVEL_W];

    // magnitude, rounded, then saturated to SAMPLE_BITS with the sine's sign
    assign w_round = (PROD_W+1)'(r_prod) + ((PROD_W+1)'(1) << 30);
    assign w_mag   = MW'(w_round[PROD_W:31]);
    assign w_sat   = w_neg ? ((w_mag > MAX_NEG) ? MAX_NEG : w_mag)
                           : ((w_mag > MAX_POS) ? MAX_POS : w_mag);
    assign w_res   = w_neg ? (MW'(0) - w_sat) : w_sat;

    if (SAMPLE_BITS >= OUT_W) begin : g_wide
        assign w_sample = w_res[OUT_W-1:0];
    end else begin : g_narrow
        assign w_sample = {{(OUT_W-SAMPLE_BITS){w_res[SAMPLE_BITS-1]}},
                           w_res[SAMPLE_BITS-1:0]};
    end

    // ---------------- sequencer ----------------
    assign w_in_beat  = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_step       = r_step;
        n_att        = r_att;
        n_dec        = r_dec;
        n_active     = r_active;
        n_prod       = r_prod;
        n_env        = r_env;
        n_res_sample = r_res_sample;
        n_res_act    = r_res_act;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_sample = r_out_sample;
        n_out_act    = r_out_act;

        unique case (r_state)
            svwe_pkg::ST_IDLE: begin
                if (w_in_beat) begin
                    if (s_axis_tuser == svwe_pkg::ACT_NOTE_ON) begin
                        n_step   = s_axis_tdata;
                        n_phase  = '0;
                        n_att    = svwe_pkg::LEVEL_ONE;
                        n_dec    = svwe_pkg::LEVEL_ONE;
                        n_active = 1'b1;
                    end else if (r_active) begin
                        n_state = svwe_pkg::ST_ENV;
                    end else begin
                        n_res_sample = '0;
                        n_res_act    = 1'b0;
                        n_state      = svwe_pkg::ST_OUT;
                    end
                end
            end
            svwe_pkg::ST_ENV: begin
                n_prod  = w_prod;
                n_state = svwe_pkg::ST_SF;
            end
            svwe_pkg::ST_SF: begin
                n_env   = w_prod_lvl;
                n_prod  = w_prod;
                n_state = svwe_pkg::ST_MAG;
            end
            svwe_pkg::ST_MAG: begin
                n_prod  = w_prod;
                n_state = svwe_pkg::ST_ATT;
            end
            svwe_pkg::ST_ATT: begin
                n_res_sample = w_sample;
                n_prod       = w_prod;
                n_state      = svwe_pkg::ST_DEC;
            end
            svwe_pkg::ST_DEC: begin
                n_att   = w_prod_lvl;
                n_prod  = w_prod;
                n_state = svwe_pkg::ST_FIN;
            end
            svwe_pkg::ST_FIN: begin
                n_dec     = w_prod_lvl;
                n_active  = !(w_prod_lvl < LEVEL_W'(r_drop));
                n_res_act = !(w_prod_lvl < LEVEL_W'(r_drop));
                n_phase   = r_phase + r_step;
                n_state   = svwe_pkg::ST_OUT;
            end
            svwe_pkg::ST_OUT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = r_res_sample;
                    n_out_act    = r_res_act;
                    n_state      = svwe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = svwe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= svwe_pkg::ST_IDLE;
            r_phase     <= '0;
            r_step      <= '0;
            r_att       <= svwe_pkg::LEVEL_ONE;
            r_dec       <= svwe_pkg::LEVEL_ONE;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_step      <= n_step;
            r_att       <= n_att;
            r_dec       <= n_dec;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod       <= n_prod;
        r_env        <= n_env;
        r_res_sample <= n_res_sample;
        r_res_act    <= n_res_act;
        r_out_sample <= n_out_sample;
        r_out_act    <= n_out_act;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_f <= svwe_pkg::ATTACK_RST;
            r_decay_f  <= svwe_pkg::DECAY_RST;
            r_fs       <= svwe_pkg::FS_RST;
            r_drop     <= svwe_pkg::DROP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                svwe_pkg::REG_ATTACK: r_attack_f <= i_cfg_data;
                svwe_pkg::REG_DECAY:  r_decay_f  <= i_cfg_data;
                svwe_pkg::REG_FS:     r_fs       <= i_cfg_data[svwe_pkg::FS_W-1:0];
                svwe_pkg::REG_DROP:   r_drop     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == svwe_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sample;
    assign m_axis_tuser  = r_out_act;

    // ---------------- checks ----------------
    a_note_on_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && s_axis_tuser == svwe_pkg::ACT_NOTE_ON
        |=> r_active && r_phase == '0 && r_att == svwe_pkg::LEVEL_ONE)
        else $error("note on did not restart the voice");

    a_levels_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_att <= svwe_pkg::LEVEL_ONE && r_dec <= svwe_pkg::LEVEL_ONE)
        else $error("envelope level above one");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == svwe_pkg::ST_OUT && w_out_free
        |=> m_axis_tvalid && s_axis_tready)
        else $error("finished result not moved to output register");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && s_axis_tuser == svwe_pkg::ACT_TICK && r_active
        |=> !s_axis_tready)
        else $error("input accepted while a tick is in progress");

endmodule

// ----- bench/sine_voice_with_envelope_top_tb.sv -----
// Self-checking bench for sine_voice_with_envelope_top: a bit-true voice model
// predicts each tick's sample; needs svwe_pkg and the RTL, nothing else.
module sine_voice_with_envelope_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_BITS    = 8;
    localparam int SMP_BITS    = 16;
    localparam int SETTLE      = 20;    // cycles after the last result before a write
    localparam int HOLD_CYCLES = 200;   // long receiver hold-off
    localparam int STALL_LIMIT = 2000;  // cycles with no beat on either side

    typedef struct packed {
        logic [svwe_pkg::OUT_W-1:0] sample;
        logic                       active;
    } t_voice_beat;

    class voice_scoreboard;
        logic [svwe_pkg::FACT_W-1:0]  attack_f;
        logic [svwe_pkg::FACT_W-1:0]  decay_f;
        logic [svwe_pkg::FS_W-1:0]    fs;
        logic [svwe_pkg::FACT_W-1:0]  drop;
        logic [svwe_pkg::PHASE_W-1:0] phase;
        logic [svwe_pkg::PHASE_W-1:0] step;
        logic [svwe_pkg::LEVEL_W-1:0] att_lvl;
        logic [svwe_pkg::LEVEL_W-1:0] dec_lvl;
        logic                         sounding;
        t_voice_beat                  pending_samples[$];
        int                           errors;

        function new();
            attack_f = svwe_pkg::ATTACK_RST;
            decay_f  = svwe_pkg::DECAY_RST;
            fs       = svwe_pkg::FS_RST;
            drop     = svwe_pkg::DROP_RST;
            phase    = '0;
            step     = '0;
            att_lvl  = svwe_pkg::LEVEL_ONE;
            dec_lvl  = svwe_pkg::LEVEL_ONE;
            sounding = 1'b0;
            errors   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                svwe_pkg::REG_ATTACK: attack_f = val;
                svwe_pkg::REG_DECAY:  decay_f  = val;
                svwe_pkg::REG_FS:     fs       = val[svwe_pkg::FS_W-1:0];
                svwe_pkg::REG_DROP:   drop     = val;
                default: ;
            endcase
        endfunction

        // Q1.15 quarter-wave magnitude, odd Taylor series in Q2.30
        function logic [svwe_pkg::SINE_W-1:0] quarter_sine(int unsigned k);
            logic [63:0] u;
            logic [63:0] u2;
            logic [63:0] acc;
            u   = 64'(k) << (30 - TBL_BITS);
            u2  = (u * u) >> 30;
            acc = 64'd172272;
            acc = 64'd5026999    - ((u2 * acc) >> 30);
            acc = 64'd85569203   - ((u2 * acc) >> 30);
            acc = 64'd693598343  - ((u2 * acc) >> 30);
            acc = 64'd1686629713 - ((u2 * acc) >> 30);
            acc = (u * acc) >> 30;
            acc = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
            if (acc > 64'd32767) acc = 64'd32767;
            return acc[svwe_pkg::SINE_W-1:0];
        endfunction

        function void take_item(logic act, logic [svwe_pkg::PHASE_W-1:0] data);
            t_voice_beat beat;
            logic [1:0]  quad;
            int unsigned k;
            logic [63:0] sine;
            logic [63:0] env;
            logic [63:0] mag;
            logic [63:0] lvl;
            if (act == svwe_pkg::ACT_NOTE_ON) begin
                step     = data;
                phase    = '0;
                att_lvl  = svwe_pkg::LEVEL_ONE;
                dec_lvl  = svwe_pkg::LEVEL_ONE;
                sounding = 1'b1;
                return;
            end
            if (!sounding) begin
                beat = '0;
                pending_samples.push_back(beat);
                return;
            end
            quad = phase[31:30];
            k    = 32'(phase[29 -: TBL_BITS]);
            sine = quad[0] ? 64'(quarter_sine((1 << TBL_BITS) - k))
                           : 64'(quarter_sine(k));
            env  = (64'(svwe_pkg::LEVEL_ONE - att_lvl) * 64'(dec_lvl)) >> 16;
            mag  = (sine * 64'(fs) * env + (64'd1 << 30)) >> 31;
            if (quad[1]) begin
                if (mag > (64'd1 << (SMP_BITS - 1))) mag = 64'd1 << (SMP_BITS - 1);
                mag = 64'd0 - mag;
            end else begin
                if (mag > (64'd1 << (SMP_BITS - 1)) - 1) mag = (64'd1 << (SMP_BITS - 1)) - 1;
            end
            beat.sample = mag[svwe_pkg::OUT_W-1:0];
            phase   = phase + step;
            lvl     = (64'(att_lvl) * 64'(attack_f)) >> 16;
            att_lvl = lvl[svwe_pkg::LEVEL_W-1:0];
            lvl     = (64'(dec_lvl) * 64'(decay_f)) >> 16;
            dec_lvl = lvl[svwe_pkg::LEVEL_W-1:0];
            if (64'(dec_lvl) < 64'(drop)) sounding = 1'b0;
            beat.active = sounding;
            pending_samples.push_back(beat);
        endfunction

        function void check_sample(logic [svwe_pkg::OUT_W-1:0] sample, logic active);
            t_voice_beat want;
            if (pending_samples.size() == 0) begin
                $error("unexpected output beat: sample %0d voice_active %0b",
                       $signed(sample), active);
                errors++;
                return;
            end
            want = pending_samples.pop_front();
            if (sample !== want.sample) begin
                $error("sample: expected %0d, actual %0d",
                       $signed(want.sample), $signed(sample));
                errors++;
            end
            if (active !== want.active) begin
                $error("voice_active: expected %0b, actual %0b", want.active, active);
                errors++;
            end
        endfunction

        function int pending();
            return pending_samples.size();
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = '0;
    logic [15:0] i_cfg_data = '0;
    logic        s_valid    = 1'b0;
    logic [31:0] s_data     = '0;
    logic        s_user     = 1'b0;
    logic        m_ready    = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;

    bit quiet    = 1'b0;   // no idling on either side
    bit hold_req = 1'b0;

    voice_scoreboard sb = new();

    sine_voice_with_envelope_top #(
        .SINE_TABLE_BITS (TBL_BITS),
        .SAMPLE_BITS     (SMP_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_ready) begin
            sb.check_sample(m_axis_tdata, m_axis_tuser);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("sine_voice_with_envelope_top test failed");
        $finish;
    end

    // Called at a clock edge; returns at the edge where the beat is taken, or later after a random idle gap.
    task automatic send_item(input logic act, input logic [31:0] data);
        s_valid <= 1'b1;
        s_data  <= data;
        s_user  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_item(act, data);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain_voice();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic program_voice(input logic [15:0] att, input logic [15:0] dec,
                                 input logic [15:0] fs, input logic [15:0] drop);
        drain_voice();
        write_reg(svwe_pkg::REG_ATTACK, att);
        write_reg(svwe_pkg::REG_DECAY, dec);
        write_reg(svwe_pkg::REG_FS, fs);
        write_reg(svwe_pkg::REG_DROP, drop);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_random();
        logic [15:0] att;
        logic [15:0] dec;
        logic [15:0] fs;
        logic [15:0] drop;
        case ($urandom_range(0, 3))
            0:       att = 16'd0;
            1:       att = 16'hFFFF;
            default: att = 16'($urandom());
        endcase
        case ($urandom_range(0, 5))
            0:       dec = 16'd0;
            1:       dec = 16'hFFFF;
            2:       dec = 16'($urandom());
            default: dec = 16'($urandom_range(60000, 65535));
        endcase
        case ($urandom_range(0, 3))
            0:       fs = 16'd0;
            1:       fs = 16'h7FFF;
            default: fs = 16'($urandom());   // bit 15 is dropped by the block
        endcase
        case ($urandom_range(0, 5))
            0:       drop = 16'd0;
            1:       drop = 16'hFFFF;
            2:       drop = 16'($urandom());
            default: drop = 16'($urandom_range(0, 8192));
        endcase
        program_voice(att, dec, fs, drop);
    endtask

    // Mostly a note-on followed by a run of ticks; some stray beats as noise
    task automatic run_random(input int n_items);
        int sent;
        int run_len;
        int unsigned pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                send_item(1'($urandom_range(0, 1)), $urandom());
                sent++;
            end else begin
                send_item(svwe_pkg::ACT_NOTE_ON,
                          (pick == 1) ? 32'($urandom_range(0, 4095)) : $urandom());
                run_len = $urandom_range(1, 60);
                repeat (run_len) send_item(svwe_pkg::ACT_TICK, $urandom());
                sent += run_len + 1;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // silent voice after reset, then default settings
        send_item(svwe_pkg::ACT_TICK, '1);
        send_item(svwe_pkg::ACT_TICK, '0);
        send_item(svwe_pkg::ACT_NOTE_ON, '0);
        repeat (2) send_item(svwe_pkg::ACT_TICK, $urandom());
        send_item(svwe_pkg::ACT_NOTE_ON, 32'h4000_0000);   // one quadrant per tick
        repeat (5) send_item(svwe_pkg::ACT_TICK, $urandom());
        send_item(svwe_pkg::ACT_NOTE_ON, '1);
        repeat (3) send_item(svwe_pkg::ACT_TICK, $urandom());
        send_item(svwe_pkg::ACT_NOTE_ON, 32'h0100_0000);
        send_item(svwe_pkg::ACT_TICK, $urandom());
        send_item(svwe_pkg::ACT_NOTE_ON, 32'h2000_0000);   // retrigger while sounding
        repeat (2) send_item(svwe_pkg::ACT_TICK, $urandom());

        // no attack, slowest decay, full scale, never stops
        program_voice(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        send_item(svwe_pkg::ACT_NOTE_ON, 32'h4000_0000);
        repeat (4) send_item(svwe_pkg::ACT_TICK, $urandom());

        // decay to zero at once: stops after the first tick
        program_voice(16'hFFFF, 16'd0, 16'h7FFF, 16'hFFFF);
        send_item(svwe_pkg::ACT_NOTE_ON, 32'h1234_5678);
        repeat (2) send_item(svwe_pkg::ACT_TICK, $urandom());

        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 9) quiet = 1'b1;
            program_random();
            if (ph == 3) hold_req = 1'b1;
            run_random(175);
        end

        drain_voice();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("sine_voice_with_envelope_top test passed");
        end else begin
            $display("sine_voice_with_envelope_top test failed");
        end
        $finish;
    end

endmodule
